FILE: rtl/can_message_reassembler_core_macros.svh
// Assertion macros shared by the CAN message reassembler RTL.
// Depends on nothing; included by cmr_datapath, the module that carries assertions.
`ifndef CAN_MESSAGE_REASSEMBLER_CORE_MACROS_SVH
`define CAN_MESSAGE_REASSEMBLER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/cmr_pkg.sv
// Types and constants of the CAN message reassembler.
// Used by cmr_datapath, cmr_ctrl and can_message_reassembler_core; depends on nothing.
`timescale 1ns / 1ps

package cmr_pkg;

	localparam logic [7:0]  STIM_BYTE    = 8'h84;
	localparam logic [16:0] HEADER_BYTES = 17'd2;
	localparam logic [3:0]  MAX_LEN      = 4'd8;

	typedef enum logic [2:0] {
		STATUS_FOREIGN = 3'd0,
		STATUS_STIM    = 3'd1,
		STATUS_STORED  = 3'd2,
		STATUS_DONE    = 3'd3,
		STATUS_EMPTY   = 3'd4
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} ctrl_state_t;

	typedef struct packed {
		logic [28:0] frame_id;
		logic [3:0]  frame_length;
		logic [7:0]  data_byte_0;
		logic [7:0]  data_byte_1;
		logic [7:0]  data_byte_2;
		logic [7:0]  data_byte_3;
		logic [7:0]  data_byte_4;
		logic [7:0]  data_byte_5;
		logic [7:0]  data_byte_6;
		logic [7:0]  data_byte_7;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [16:0] byte_offset;
		logic [7:0]  byte_value;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic emit_single;
		logic emit_byte;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic single;
		logic final_byte;
	} dp_status_t;

endpackage

FILE: rtl/cmr_datapath.sv
// Datapath of the CAN message reassembler: frame register, message state and result register.
// Depends on cmr_pkg and can_message_reassembler_core_macros.svh; driven by cmr_ctrl.
`timescale 1ns / 1ps
`include "can_message_reassembler_core_macros.svh"

module cmr_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [28:0]         cfg_data,
	input  cmr_pkg::in_item_t   in_data,
	input  cmr_pkg::dp_cmd_t    cmd,
	output cmr_pkg::dp_status_t sts,
	input  logic                out_ready,
	output logic                out_valid,
	output cmr_pkg::out_item_t  out_data
);

	logic [28:0]        accepted_id_q;
	cmr_pkg::in_item_t  frame_q;
	logic [3:0]         len_q;
	logic [2:0]         idx_q;
	logic [16:0]        byte_count_q;
	logic [15:0]        length_header_q;
	logic               out_valid_q;
	cmr_pkg::out_item_t out_q;

	logic [7:0]       cur_byte;
	logic [15:0]      lh_new;
	logic [16:0]      cnt_next;
	logic [16:0]      total;
	logic             complete;
	logic             last_in_frame;
	logic             foreign;
	logic             stim;
	logic             empty;
	cmr_pkg::status_t single_status;

	always_comb begin
		case (idx_q)
			3'd0: cur_byte = frame_q.data_byte_0;
			3'd1: cur_byte = frame_q.data_byte_1;
			3'd2: cur_byte = frame_q.data_byte_2;
			3'd3: cur_byte = frame_q.data_byte_3;
			3'd4: cur_byte = frame_q.data_byte_4;
			3'd5: cur_byte = frame_q.data_byte_5;
			3'd6: cur_byte = frame_q.data_byte_6;
			3'd7: cur_byte = frame_q.data_byte_7;
			default: cur_byte = frame_q.data_byte_0;
		endcase
	end

	always_comb begin
		if (byte_count_q == 17'd0) begin
			lh_new = {length_header_q[15:8], cur_byte};
		end else if (byte_count_q == 17'd1) begin
			lh_new = {cur_byte, length_header_q[7:0]};
		end else begin
			lh_new = length_header_q;
		end
		cnt_next      = byte_count_q + 17'd1;
		total         = {1'b0, lh_new} + cmr_pkg::HEADER_BYTES;
		complete      = (cnt_next >= total);
		last_in_frame = (({1'b0, idx_q} + 4'd1) == len_q);

		foreign = (frame_q.frame_id != accepted_id_q);
		stim    = (byte_count_q == 17'd0) && (len_q == 4'd1)
			&& (frame_q.data_byte_0 == cmr_pkg::STIM_BYTE);
		empty   = (len_q == 4'd0);
		if (foreign) begin
			single_status = cmr_pkg::STATUS_FOREIGN;
		end else if (stim) begin
			single_status = cmr_pkg::STATUS_STIM;
		end else begin
			single_status = cmr_pkg::STATUS_EMPTY;
		end

		sts.slot_free  = !out_valid_q || out_ready;
		sts.single     = foreign || stim || empty;
		sts.final_byte = complete || last_in_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_id_q <= '0;
		end else if (cfg_valid) begin
			accepted_id_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			frame_q <= in_data;
			len_q   <= (in_data.frame_length > cmr_pkg::MAX_LEN) ? cmr_pkg::MAX_LEN
				: in_data.frame_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q           <= '0;
			byte_count_q    <= '0;
			length_header_q <= '0;
		end else if (cmd.capture) begin
			idx_q <= '0;
		end else if (cmd.emit_byte) begin
			idx_q           <= idx_q + 3'd1;
			byte_count_q    <= complete ? 17'd0 : cnt_next;
			length_header_q <= lh_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_single || cmd.emit_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_single) begin
			out_q.status      <= single_status;
			out_q.byte_offset <= '0;
			out_q.byte_value  <= '0;
			out_q.last        <= 1'b1;
		end else if (cmd.emit_byte) begin
			out_q.status      <= complete ? cmr_pkg::STATUS_DONE : cmr_pkg::STATUS_STORED;
			out_q.byte_offset <= byte_count_q;
			out_q.byte_value  <= cur_byte;
			out_q.last        <= complete || last_in_frame;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`CMR_ASSERT_NEXT(a_done_restarts, clk, arst_n, cmd.emit_byte && complete, byte_count_q == 17'd0, "Completed message did not restart the byte count.")
	`CMR_ASSERT_SAME(a_byte_needs_data, clk, arst_n, cmd.emit_byte, !sts.single && (len_q != 4'd0) && ({1'b0, idx_q} < len_q), "Byte emitted from a frame that has none left.")
	`CMR_ASSERT_SAME(a_one_load, clk, arst_n, cmd.emit_single || cmd.emit_byte, sts.slot_free && !(cmd.emit_single && cmd.emit_byte) && !cmd.capture, "Result register loaded while occupied or twice.")
	`CMR_ASSERT_NEXT(a_idx_steps, clk, arst_n, cmd.emit_byte && !sts.final_byte, idx_q == $past(idx_q) + 3'd1, "Byte index did not advance.")

endmodule

FILE: rtl/cmr_ctrl.sv
// Controller of the CAN message reassembler: accepts one frame, then steps through its results.
// Depends on cmr_pkg; commands cmr_datapath.
`timescale 1ns / 1ps

module cmr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cmr_pkg::dp_status_t sts,
	output cmr_pkg::dp_cmd_t    cmd
);

	cmr_pkg::ctrl_state_t state_q;
	cmr_pkg::ctrl_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmr_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			cmr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_next  = cmr_pkg::ST_RUN;
				end
			end
			cmr_pkg::ST_RUN: begin
				if (sts.slot_free) begin
					if (sts.single) begin
						cmd.emit_single = 1'b1;
						state_next      = cmr_pkg::ST_IDLE;
					end else begin
						cmd.emit_byte = 1'b1;
						if (sts.final_byte) begin
							state_next = cmr_pkg::ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_next = cmr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/can_message_reassembler_core.sv
// CAN message reassembler: frame input, per-byte result output, one ID register.
// Depends on cmr_pkg, cmr_ctrl and cmr_datapath.
// Usage:
//   The in channel takes one received CAN frame per request (in_data: id, length code,
//   eight data bytes). The out channel gives one result per request: a status, the byte
//   offset in the message, the byte value and a last flag on the frame's final result.
//   The cfg channel writes the accepted frame identifier; it is always ready. The user must see that it is
//   written only while no frame is in work; the block itself does not enforce this.
//   A frame is captured into the frame register, and its first result is loaded into the output
//   register once that register is free. A frame that is foreign, a stimulation answer or empty
//   gives one result; otherwise one result per stored byte, one per cycle while the output
//   register is free, up to eight, ending early when the message completes.
//   The next frame is accepted while the last result still waits in the output register.
//   If the receiver stalls, the stepping pauses until the output register is free.
//   Reset clears the byte count, the length header, the ID register and all valids.
`timescale 1ns / 1ps

module can_message_reassembler_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [28:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  cmr_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output cmr_pkg::out_item_t out_data
);

	cmr_pkg::dp_cmd_t    cmd;
	cmr_pkg::dp_status_t sts;

	assign cfg_ready = 1'b1;

	cmr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cmr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
